### design/rrpd_pkg.sv
// Shared constants, phase codes, result kinds and the job type for the radial RLE decoder.
package rrpd_pkg;

    localparam int HEADER_BYTES = 170;
    localparam int NUM_RADIALS  = 360;
    localparam int SKIP_BYTES   = 8;
    localparam int ANGLE_SKIP   = 2;
    localparam int ANGLE_BASE   = 4500;

    localparam int VALUE_W = 17;
    localparam int KIND_W  = 2;
    localparam int RUN_W   = 4;
    localparam int PHASE_W = 4;
    localparam int BCNT_W  = 8;
    localparam int RAD_W   = 9;
    localparam int LEFT_W  = 17;

    localparam logic [PHASE_W-1:0] PH_HDR     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_BINS_HI = 4'd1;
    localparam logic [PHASE_W-1:0] PH_BINS_LO = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP8   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_CNT_HI  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CNT_LO  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ANG_HI  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ANG_LO  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SKIP2   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RLE     = 4'd9;
    localparam logic [PHASE_W-1:0] PH_DONE    = 4'd10;

    localparam logic [PHASE_W-1:0] PH_START =
        (HEADER_BYTES == 0) ? PH_BINS_HI : PH_HDR;

    localparam logic [KIND_W-1:0] KIND_BINS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LEVEL = 2'd2;

    // One decoded input byte: a result value repeated count times.
    typedef struct packed {
        logic                      valid;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [RUN_W-1:0]          count;
    } t_job;

endpackage

### design/rrpd_parser.sv
// Product stream parser: walks the header, radial headers and RLE bytes and issues jobs.
module rrpd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte_value,
    input  logic             i_frame_start,
    output rrpd_pkg::t_job   o_job
);

    logic [rrpd_pkg::PHASE_W-1:0] r_phase, n_phase, e_phase;
    logic [rrpd_pkg::BCNT_W-1:0]  r_byte_count, n_byte_count, e_byte_count;
    logic [rrpd_pkg::RAD_W-1:0]   r_radial, n_radial, e_radial;
    logic [rrpd_pkg::LEFT_W-1:0]  r_left, n_left, e_left;
    logic [7:0]                   r_high, n_high, e_high;
    logic [15:0]                  half;
    rrpd_pkg::t_job               job;

    // A frame start restarts decoding with this very byte.
    always_comb begin
        if (i_frame_start) begin
            e_phase      = rrpd_pkg::PH_START;
            e_byte_count = '0;
            e_radial     = '0;
            e_left       = '0;
            e_high       = '0;
        end else begin
            e_phase      = r_phase;
            e_byte_count = r_byte_count;
            e_radial     = r_radial;
            e_left       = r_left;
            e_high       = r_high;
        end
    end

    assign half = {e_high, i_byte_value};

    always_comb begin
        n_phase      = e_phase;
        n_byte_count = e_byte_count;
        n_radial     = e_radial;
        n_left       = e_left;
        n_high       = e_high;
        job          = '0;
        case (e_phase)
            rrpd_pkg::PH_HDR: begin
                n_byte_count = e_byte_count + 1'b1;
                if (n_byte_count >= rrpd_pkg::BCNT_W'(rrpd_pkg::HEADER_BYTES)) begin
                    n_byte_count = '0;
                    n_phase      = rrpd_pkg::PH_BINS_HI;
                end
            end
            rrpd_pkg::PH_BINS_HI: begin
                n_high  = i_byte_value;
                n_phase = rrpd_pkg::PH_BINS_LO;
            end
            rrpd_pkg::PH_BINS_LO: begin
                job.valid    = 1'b1;
                job.kind     = rrpd_pkg::KIND_BINS;
                job.value    = {1'b0, half};
                job.count    = rrpd_pkg::RUN_W'(1);
                n_byte_count = '0;
                n_phase      = rrpd_pkg::PH_SKIP8;
            end
            rrpd_pkg::PH_SKIP8: begin
                n_byte_count = e_byte_count + 1'b1;
                if (n_byte_count >= rrpd_pkg::BCNT_W'(rrpd_pkg::SKIP_BYTES)) begin
                    n_byte_count = '0;
                    n_phase      = rrpd_pkg::PH_CNT_HI;
                end
            end
            rrpd_pkg::PH_CNT_HI: begin
                n_high  = i_byte_value;
                n_phase = rrpd_pkg::PH_CNT_LO;
            end
            rrpd_pkg::PH_CNT_LO: begin
                // Halfword count of RLE data, turned into a byte count.
                n_left  = {half, 1'b0};
                n_phase = rrpd_pkg::PH_ANG_HI;
            end
            rrpd_pkg::PH_ANG_HI: begin
                n_high  = i_byte_value;
                n_phase = rrpd_pkg::PH_ANG_LO;
            end
            rrpd_pkg::PH_ANG_LO: begin
                job.valid    = 1'b1;
                job.kind     = rrpd_pkg::KIND_ANGLE;
                job.value    = rrpd_pkg::VALUE_W'(rrpd_pkg::ANGLE_BASE) - {1'b0, half};
                job.count    = rrpd_pkg::RUN_W'(1);
                n_byte_count = '0;
                n_phase      = rrpd_pkg::PH_SKIP2;
            end
            rrpd_pkg::PH_SKIP2: begin
                n_byte_count = e_byte_count + 1'b1;
                if (n_byte_count >= rrpd_pkg::BCNT_W'(rrpd_pkg::ANGLE_SKIP)) begin
                    n_byte_count = '0;
                    if (e_left == '0) begin
                        n_radial = e_radial + 1'b1;
                        n_phase  = (n_radial >= rrpd_pkg::RAD_W'(rrpd_pkg::NUM_RADIALS)) ?
                                   rrpd_pkg::PH_DONE : rrpd_pkg::PH_CNT_HI;
                    end else begin
                        n_phase = rrpd_pkg::PH_RLE;
                    end
                end
            end
            rrpd_pkg::PH_RLE: begin
                job.valid = (i_byte_value[7:4] != '0);
                job.kind  = rrpd_pkg::KIND_LEVEL;
                job.value = {13'd0, i_byte_value[3:0]};
                job.count = i_byte_value[7:4];
                n_left    = e_left - 1'b1;
                if (n_left == '0) begin
                    n_radial = e_radial + 1'b1;
                    n_phase  = (n_radial >= rrpd_pkg::RAD_W'(rrpd_pkg::NUM_RADIALS)) ?
                               rrpd_pkg::PH_DONE : rrpd_pkg::PH_CNT_HI;
                end
            end
            default: begin
                n_phase = rrpd_pkg::PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rrpd_pkg::PH_START;
            r_byte_count <= '0;
            r_radial     <= '0;
            r_left       <= '0;
            r_high       <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_radial     <= n_radial;
            r_left       <= n_left;
            r_high       <= n_high;
        end
    end

    assign o_job = job;

endmodule

### design/rrpd_emitter.sv
// Result emitter: repeats one job's value through the output register under a run counter.
module rrpd_emitter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  rrpd_pkg::t_job                   i_job,
    output logic                             o_busy,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [rrpd_pkg::KIND_W-1:0]      o_kind,
    output logic signed [rrpd_pkg::VALUE_W-1:0] o_value,
    output logic                             o_last
);

    logic                               r_valid;
    logic [rrpd_pkg::KIND_W-1:0]        r_kind;
    logic signed [rrpd_pkg::VALUE_W-1:0] r_value;
    logic [rrpd_pkg::RUN_W-1:0]         r_left;
    logic                               take;
    logic                               final_one;

    assign take      = r_valid && !i_stall;
    assign final_one = (r_left == rrpd_pkg::RUN_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (i_load && i_job.valid) begin
            r_valid <= 1'b1;
            r_left  <= i_job.count;
        end else if (take) begin
            r_left <= r_left - 1'b1;
            if (final_one) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_job.valid) begin
            r_kind  <= i_job.kind;
            r_value <= i_job.value;
        end
    end

    assign o_busy  = r_valid;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = final_one;

endmodule

### design/radial_rle_product_decoder_core.sv
// Top level of the radial RLE product decoder: byte parser feeding a run-length emitter.
// A byte with results shows its first result in the cycle after its transaction.
// A byte with no result raises no stall; while a byte's results are given out, o_stall
// holds the next byte back. Runs are up to 15 long, set by the emitter's run counter
// stepping once per result, and i_stall holds the run. Reset (synchronous, active low)
// restarts the parser at the header skip and empties the output register.
module radial_rle_product_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_byte_value,
    input  logic                                i_frame_start,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rrpd_pkg::KIND_W-1:0]         o_kind,
    output logic signed [rrpd_pkg::VALUE_W-1:0] o_value,
    output logic                                o_last
);

    logic           accept;
    logic           busy;
    rrpd_pkg::t_job job;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    rrpd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_value (i_byte_value),
        .i_frame_start(i_frame_start),
        .o_job        (job)
    );

    rrpd_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_job   (job),
        .o_busy  (busy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_kind  (o_kind),
        .o_value (o_value),
        .o_last  (o_last)
    );

endmodule
